// ----- design/rgma_pkg.sv -----
// Package: shared constants and codes of the range-gated moving average.
`default_nettype none

package rgma_pkg;

  localparam int unsigned DIST_W     = 12;
  localparam int unsigned CNT_OUT_W  = 4;
  localparam int unsigned CNT_MAX    = 15;
  localparam int unsigned DEPTH_DEF  = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [DIST_W-1:0] MIN_DIST_RST = 12'd32;
  localparam logic [DIST_W-1:0] MAX_DIST_RST = 12'd2080;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'd1;

endpackage

`default_nettype wire

// ----- design/rgma_in_if.sv -----
// Interface: input item channel (sample or clear).
`default_nettype none

interface rgma_in_if;
  import rgma_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [DIST_W-1:0] distance;
  logic              present;

  modport source (output valid, output kind, output distance, output present, input ready);
  modport sink   (input valid, input kind, input distance, input present, output ready);
endinterface

`default_nettype wire

// ----- design/rgma_out_if.sv -----
// Interface: result item channel.
`default_nettype none

interface rgma_out_if;
  import rgma_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DIST_W-1:0]    average;
  logic                 has_average;
  logic [CNT_OUT_W-1:0] used_count;

  modport source (output valid, output average, output has_average, output used_count,
                  input ready);
  modport sink   (input valid, input average, input has_average, input used_count,
                  output ready);
endinterface

`default_nettype wire

// ----- design/rgma_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rgma_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/range_gated_moving_average.sv -----
// Top level: range-gated moving average over a ring of distance samples.
// Each sample item is written into a ring of DEPTH entries, then the ring is
// read back one entry per cycle from RAM; present entries within
// [min_distance, max_distance] are summed and counted, and the sum is divided
// by the count in a bit-serial restoring divider, one quotient bit per cycle.
// A sample item occupies the block through the RAM scan, the divide and the
// result load. A clear item produces no result and leaves the block ready.
// Entry present flags live in flip-flops cleared at reset, so no clearing pass
// is needed. The result sits in an output register, so the next item can be
// accepted while it waits to be taken. Configuration must be written only
// while idle; the block itself does not enforce it.
`default_nettype none

module range_gated_moving_average #(
  parameter int unsigned DEPTH = rgma_pkg::DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rgma_in_if.sink                             in_if,
  rgma_out_if.source                          out_if,
  input  wire logic                           cfg_we_i,
  input  wire logic [rgma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgma_pkg::DIST_W-1:0]    cfg_data_i
);
  import rgma_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = DIST_W + CW;
  localparam int unsigned BW = $clog2(SW);
  localparam int unsigned UW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [DEPTH-1:0]  vld_q, vld_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic              pend_q, pend_d;
  logic [SW-1:0]     sum_q, sum_d;
  logic [CW-1:0]     used_q, used_d;
  logic [CW:0]       rem_q, rem_d;
  logic [BW-1:0]     bit_q, bit_d;
  logic [DIST_W-1:0] min_q, max_q;
  logic              out_valid_q, out_valid_d;

  logic [DIST_W-1:0]    avg_q;
  logic                 has_q;
  logic [CNT_OUT_W-1:0] cnt_q;

  logic              in_acc;
  logic              ram_we;
  logic [DIST_W-1:0] ram_rdata;
  logic              hit;
  logic [CW:0]       rem_sh;
  logic              ge;
  logic              load_out;
  logic [UW-1:0]     used_ext;
  logic [CNT_OUT_W-1:0] used_sat;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ram_we      = in_acc && (in_if.kind == KIND_SAMPLE);

  rgma_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_if.distance),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign hit    = pend_q && (ram_rdata >= min_q) && (ram_rdata <= max_q);
  assign rem_sh = {rem_q[CW-1:0], sum_q[SW-1]};
  assign ge     = (rem_sh >= {1'b0, used_q});
  assign load_out = (state_q == ST_LOAD) && (!out_valid_q || out_if.ready);

  assign used_ext = UW'(used_q);
  assign used_sat = (used_ext > UW'(CNT_MAX)) ? CNT_OUT_W'(CNT_MAX)
                                              : used_ext[CNT_OUT_W-1:0];

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    vld_d   = vld_q;
    idx_d   = idx_q;
    pend_d  = 1'b0;
    sum_d   = sum_q;
    used_d  = used_q;
    rem_d   = rem_q;
    bit_d   = bit_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.kind == KIND_CLEAR) begin
            vld_d = '0;
            wp_d  = '0;
          end else begin
            vld_d[wp_q] = in_if.present;
            wp_d    = (wp_q == LAST) ? '0 : wp_q + 1'b1;
            idx_d   = '0;
            sum_d   = '0;
            used_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_d = vld_q[idx_q];
        idx_d  = idx_q + 1'b1;
        if (hit) begin
          sum_d  = sum_q + SW'(ram_rdata);
          used_d = used_q + 1'b1;
        end
        if (idx_q == LAST) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (hit) begin
          sum_d  = sum_q + SW'(ram_rdata);
          used_d = used_q + 1'b1;
        end
        rem_d   = '0;
        bit_d   = BW'(SW - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, dividend shifts out as quotient shifts in
        rem_d = ge ? (rem_sh - {1'b0, used_q}) : rem_sh;
        sum_d = {sum_q[SW-2:0], ge};
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      vld_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      used_q      <= '0;
      bit_q       <= '0;
      min_q       <= MIN_DIST_RST;
      max_q       <= MAX_DIST_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      vld_q       <= vld_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      used_q      <= used_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIN_DIST: min_q <= cfg_data_i;
          REG_MAX_DIST: max_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    rem_q <= rem_d;
    if (load_out) begin
      avg_q <= (used_q == '0) ? '0 : sum_q[DIST_W-1:0];
      has_q <= (used_q != '0);
      cnt_q <= used_sat;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.average     = avg_q;
  assign out_if.has_average = has_q;
  assign out_if.used_count  = cnt_q;

endmodule

`default_nettype wire

// ----- design/rgma_chk.sv -----
// Checker: port-level assertions for the range-gated moving average, and its bind.
`default_nettype none

module rgma_chk #(
  parameter int unsigned DEPTH = rgma_pkg::DEPTH_DEF
) (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           in_kind,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [rgma_pkg::DIST_W-1:0]    average,
  input wire logic                           has_average,
  input wire logic [rgma_pkg::CNT_OUT_W-1:0] used_count
);
  import rgma_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(average) && $stable(has_average)
      && $stable(used_count))
    else $error("result changed while stalled");

  a_no_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !has_average |-> (average == '0) && (used_count == '0))
    else $error("empty result carries nonzero fields");

  a_has_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && has_average |-> (used_count != '0) && (32'(used_count) <= DEPTH))
    else $error("used count inconsistent with has_average");

  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == KIND_SAMPLE) |=> !in_ready)
    else $error("sample item did not occupy the block");

  a_clear_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_kind == KIND_CLEAR) |=> in_ready)
    else $error("clear item did not finish in one cycle");

endmodule

bind range_gated_moving_average rgma_chk #(
  .DEPTH (DEPTH)
) u_rgma_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_kind     (in_if.kind),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .average     (out_if.average),
  .has_average (out_if.has_average),
  .used_count  (out_if.used_count)
);

`default_nettype wire

// ----- test/rgma_average_checker.sv -----
// Checker: predicts and compares the results of the range-gated moving average.
`timescale 1ns / 1ps

module rgma_average_checker #(
  parameter int unsigned DEPTH = rgma_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rgma_in_if                             in_mon,
  rgma_out_if                            out_mon,
  input  logic                           cfg_we_i,
  input  logic [rgma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgma_pkg::DIST_W-1:0]    cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    fail_count_o
);
  import rgma_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]    average;
    logic                 has_average;
    logic [CNT_OUT_W-1:0] used_count;
  } avg_result_t;

  logic [DIST_W-1:0] ring_dist [DEPTH];
  logic              ring_present [DEPTH];
  int unsigned       wr_slot;
  int unsigned       filled;
  logic [DIST_W-1:0] gate_min;
  logic [DIST_W-1:0] gate_max;
  avg_result_t       expected_q [$];
  int unsigned       fails = 0;

  task automatic clear_ring();
    for (int i = 0; i < DEPTH; i++) begin
      ring_dist[i] = '0;
      ring_present[i] = 1'b0;
    end
    wr_slot = 0;
    filled = 0;
  endtask

  task automatic store_and_average(input logic [DIST_W-1:0] sample_dist,
                                   input logic present, output avg_result_t res);
    int unsigned sum;
    int unsigned used;
    sum = 0;
    used = 0;
    ring_dist[wr_slot] = sample_dist;
    ring_present[wr_slot] = present;
    wr_slot = (wr_slot + 1 >= DEPTH) ? 0 : wr_slot + 1;
    if (filled < DEPTH) filled++;
    for (int i = 0; i < filled; i++) begin
      if (ring_present[i] && ring_dist[i] >= gate_min && ring_dist[i] <= gate_max) begin
        sum += ring_dist[i];
        used++;
      end
    end
    res.average = (used > 0) ? DIST_W'(sum / used) : '0;
    res.has_average = (used > 0);
    res.used_count = (used > CNT_MAX) ? CNT_OUT_W'(CNT_MAX) : CNT_OUT_W'(used);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    avg_result_t got;
    avg_result_t want;
    avg_result_t fresh;
    if (!rst_ni) begin
      clear_ring();
      gate_min = MIN_DIST_RST;
      gate_max = MAX_DIST_RST;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.average, out_mon.has_average, out_mon.used_count};
        if (expected_q.size() == 0) begin
          $error("unexpected result: average %0d has_average %0d used_count %0d",
                 got.average, got.has_average, got.used_count);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (got.average !== want.average) begin
            $error("average: expected %0d, actual %0d", want.average, got.average);
            fails++;
          end
          if (got.has_average !== want.has_average) begin
            $error("has_average: expected %0d, actual %0d", want.has_average,
                   got.has_average);
            fails++;
          end
          if (got.used_count !== want.used_count) begin
            $error("used_count: expected %0d, actual %0d", want.used_count,
                   got.used_count);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_CLEAR) begin
          clear_ring();
        end else begin
          store_and_average(in_mon.distance, in_mon.present, fresh);
          expected_q.push_back(fresh);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MIN_DIST) gate_min = cfg_data_i;
        else if (cfg_idx_i == REG_MAX_DIST) gate_max = cfg_data_i;
      end
    end
    pending_o <= expected_q.size();
    fail_count_o <= fails;
  end

endmodule

// ----- test/range_gated_moving_average_test.sv -----
// Testbench top: stimulus, idling and verdict for the range-gated moving average.
`timescale 1ns / 1ps

module range_gated_moving_average_test;
  import rgma_pkg::*;

  localparam int unsigned BUSY_CYCLES = DEPTH_DEF + 12 + $clog2(DEPTH_DEF + 1) + 3;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 250;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIST_W-1:0]    cfg_data;
  int unsigned          pending;
  int unsigned          fail_count;
  int unsigned          cycles = 0;
  int unsigned          tx_idle_pct = 0;
  int unsigned          rx_idle_pct = 0;
  bit                   hold_req = 1'b0;
  logic [DIST_W-1:0]    cur_min;
  logic [DIST_W-1:0]    cur_max;

  rgma_in_if  in_ch ();
  rgma_out_if out_ch ();

  range_gated_moving_average dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rgma_average_checker avg_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic kind, input logic [DIST_W-1:0] sample_dist,
                           input logic present);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.distance <= sample_dist;
    in_ch.present  <= present;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  task automatic set_gate(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_MIN_DIST;
    cfg_data <= lo;
    @(posedge clk);
    cfg_idx  <= REG_MAX_DIST;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_min = lo;
    cur_max = hi;
  endtask

  task automatic random_gate();
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
    a = DIST_W'($urandom);
    b = DIST_W'($urandom);
    case ($urandom_range(5))
      0: set_gate('0, '1);
      1: set_gate((a > b) ? a : b, (a > b) ? b : a);
      2: set_gate(a, a);
      default: set_gate((a < b) ? a : b, (a < b) ? b : a);
    endcase
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return cur_min;
      1: return cur_max;
      2: return cur_min - 1'b1;
      3: return cur_max + 1'b1;
      4, 5: return DIST_W'($urandom);
      default: begin
        if (cur_min <= cur_max) return DIST_W'($urandom_range(cur_max, cur_min));
        return DIST_W'($urandom);
      end
    endcase
  endfunction

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input bit with_hold);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 50 == 0) random_gate();
      if (with_hold && n == 10) hold_req = 1'b1;
      send_item(($urandom_range(19) == 0) ? KIND_CLEAR : KIND_SAMPLE, pick_distance(),
                $urandom_range(7) != 0);
    end
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.kind     <= KIND_SAMPLE;
    in_ch.distance <= '0;
    in_ch.present  <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_MIN_DIST;
    cfg_data       <= '0;
    cur_min = MIN_DIST_RST;
    cur_max = MAX_DIST_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset bounds, just inside and just outside
    send_item(KIND_SAMPLE, MIN_DIST_RST, 1'b1);
    send_item(KIND_SAMPLE, MAX_DIST_RST, 1'b1);
    send_item(KIND_SAMPLE, MIN_DIST_RST - 1'b1, 1'b1);
    send_item(KIND_SAMPLE, MAX_DIST_RST + 1'b1, 1'b1);
    send_item(KIND_SAMPLE, 12'd1000, 1'b0);
    send_item(KIND_SAMPLE, 12'd0, 1'b1);
    send_item(KIND_SAMPLE, 12'hFFF, 1'b1);
    send_item(KIND_SAMPLE, 12'd555, 1'b1);
    send_item(KIND_SAMPLE, 12'd777, 1'b1);
    send_item(KIND_SAMPLE, 12'd1234, 1'b1);
    send_item(KIND_CLEAR, 12'hFFF, 1'b1);
    send_item(KIND_SAMPLE, 12'd100, 1'b0);
    send_item(KIND_CLEAR, 12'd0, 1'b0);

    // widest gate: full ring of top values, then wrap
    set_gate('0, '1);
    repeat (8) send_item(KIND_SAMPLE, 12'hFFF, 1'b1);
    send_item(KIND_SAMPLE, 12'd0, 1'b1);

    // min above max: nothing qualifies
    set_gate('1, '0);
    send_item(KIND_SAMPLE, 12'd2000, 1'b1);
    send_item(KIND_SAMPLE, 12'hFFF, 1'b1);

    run_phase(18, 79, 1'b0);
    run_phase(79, 18, 1'b0);
    run_phase(0, 0, 1'b1);

    drain();
    repeat (BUSY_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
